// ===== src/pfe_pkg.sv =====
package pfe_pkg;

  localparam int unsigned SquareCells   = 25;
  localparam int unsigned SquareSide    = 5;
  localparam int unsigned AlphabetSize  = 26;
  localparam int unsigned LetterSpace   = 32;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [4:0] FillerLetter = 5'd23;
  localparam logic [4:0] KeepReset    = 5'd8;
  localparam logic [4:0] DropReset    = 5'd9;

  localparam logic [7:0] AsciiUpperA = 8'd65;
  localparam logic [7:0] AsciiUpperZ = 8'd90;
  localparam logic [7:0] AsciiLowerA = 8'd97;
  localparam logic [7:0] AsciiLowerZ = 8'd122;

  typedef enum logic [1:0] {
    KIND_KEY_CHAR = 2'd0,
    KIND_KEY_END  = 2'd1,
    KIND_MSG_CHAR = 2'd2,
    KIND_MSG_END  = 2'd3
  } kind_e;

  typedef enum logic {
    REG_MERGE_KEEP = 1'b0,
    REG_MERGE_DROP = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS,
    ST_SQ,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] letter;
  } op_t;

  typedef struct packed {
    logic [4:0] keep;
    logic [4:0] drop;
  } cfg_t;

  function automatic logic [2:0] pos_row(input logic [4:0] p);
    logic [2:0] r;
    r = 3'd0;
    for (int unsigned i = 1; i < SquareSide; i++) begin
      if (p >= 5'(i * SquareSide)) r = 3'(i);
    end
    return r;
  endfunction

  function automatic logic [2:0] pos_col(input logic [4:0] p);
    logic [4:0] t;
    t = p - 5'(pos_row(p) * SquareSide);
    return t[2:0];
  endfunction

  function automatic logic [2:0] step_wrap(input logic [2:0] v);
    return (v == 3'(SquareSide - 1)) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return 5'(r * SquareSide + c);
  endfunction

endpackage

// ===== src/pfe_if.sv =====
interface pfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;

  modport source (output valid, kind, char_code, input ready);
  modport sink   (input valid, kind, char_code, output ready);
endinterface

interface pfe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_first;
  logic [6:0] cipher_second;

  modport source (output valid, cipher_first, cipher_second, input ready);
  modport sink   (input valid, cipher_first, cipher_second, output ready);
endinterface

// ===== src/pfe_ram.sv =====
module pfe_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/pfe_front.sv =====
module pfe_front import pfe_pkg::*; (
  pfe_in_if.sink in_i,
  input  cfg_t   cfg_i,
  input  logic   queue_full_i,
  output logic   push_o,
  output op_t    push_data_o
);

  kind_e      kind;
  logic [7:0] c;
  logic       is_letter;
  logic [4:0] letter;
  logic       keep_item;

  assign kind = kind_e'(in_i.kind);
  assign c    = in_i.char_code;

  always_comb begin
    is_letter = 1'b0;
    letter    = 5'd0;
    if (c >= AsciiUpperA && c <= AsciiUpperZ) begin
      is_letter = 1'b1;
      letter    = 5'(c - AsciiUpperA);
    end else if (c >= AsciiLowerA && c <= AsciiLowerZ) begin
      is_letter = 1'b1;
      letter    = 5'(c - AsciiLowerA);
    end
  end

  // drop non-letters and the dropped key letter here; map message letters
  always_comb begin
    keep_item        = 1'b1;
    push_data_o.kind   = kind;
    push_data_o.letter = 5'd0;
    case (kind)
      KIND_KEY_CHAR: begin
        keep_item          = is_letter && (letter != cfg_i.drop);
        push_data_o.letter = letter;
      end
      KIND_MSG_CHAR: begin
        keep_item          = is_letter;
        push_data_o.letter = (letter == cfg_i.drop) ? cfg_i.keep : letter;
      end
      default: begin
        keep_item = 1'b1;
      end
    endcase
  end

  assign in_i.ready = !queue_full_i;
  assign push_o     = in_i.valid && !queue_full_i && keep_item;

endmodule

// ===== src/pfe_queue.sv =====
module pfe_queue import pfe_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_data_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  pop_data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             slot_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/pfe_back.sv =====
module pfe_back import pfe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  op_t       q_data_i,
  output logic      q_pop_o,
  pfe_out_if.source out_o
);

  back_state_e state_q, state_d;

  logic [AlphabetSize-1:0] used_q, used_d;
  logic [4:0] fill_q, fill_d;
  logic [4:0] fill_idx_q, fill_idx_d;
  logic [4:0] pend_q, pend_d;
  logic       pend_valid_q, pend_valid_d;
  logic [4:0] pair_a_q, pair_a_d, pair_b_q, pair_b_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_first_q, out_first_d, out_second_q, out_second_d;

  logic       place_req, place_ok, letter_free;
  logic [4:0] place_letter;
  logic       pos_re, sq_re;
  logic [4:0] pos_rd_a, pos_rd_b, sq_rd_a, sq_rd_b;
  logic [4:0] pa, pb, qa, qb;
  logic [2:0] ra, ca, rb, cb;
  logic       found_a, found_b;
  logic       slot_free, out_load;
  logic       pair_go;

  assign slot_free = !out_valid_q || out_o.ready;

  // letter -> cell position
  pfe_ram #(.Width(5), .Depth(LetterSpace)) u_pos_ram (
    .clk_i     (clk_i),
    .we_i      (place_ok),
    .waddr_i   (place_letter),
    .wdata_i   (fill_q),
    .re_i      (pos_re),
    .raddr_a_i (pair_a_q),
    .raddr_b_i (pair_b_q),
    .rdata_a_o (pos_rd_a),
    .rdata_b_o (pos_rd_b)
  );

  // cell -> letter
  pfe_ram #(.Width(5), .Depth(SquareCells)) u_sq_ram (
    .clk_i     (clk_i),
    .we_i      (place_ok),
    .waddr_i   (fill_q),
    .wdata_i   (place_letter),
    .re_i      (sq_re),
    .raddr_a_i (qa),
    .raddr_b_i (qb),
    .rdata_a_o (sq_rd_a),
    .rdata_b_o (sq_rd_b)
  );

  // pair decision from the pending letter
  always_comb begin
    pair_go = 1'b0;
    if (state_q == ST_IDLE && !q_empty_i) begin
      case (q_data_i.kind)
        KIND_MSG_CHAR: pair_go = pend_valid_q;
        KIND_MSG_END:  pair_go = pend_valid_q;
        default:       pair_go = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.kind == KIND_KEY_END) begin
            state_d = ST_FILL;
          end else if (pair_go) begin
            state_d = ST_POS;
          end
        end
      end
      ST_FILL: begin
        if (fill_idx_q == 5'(AlphabetSize - 1)) state_d = ST_IDLE;
      end
      ST_POS:  state_d = ST_SQ;
      ST_SQ:   state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o      = (state_q == ST_IDLE) && !q_empty_i;
    place_req    = 1'b0;
    place_letter = q_data_i.letter;
    fill_idx_d   = fill_idx_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    pair_a_d     = pair_a_q;
    pair_b_d     = pair_b_q;
    pos_re       = 1'b0;
    sq_re        = 1'b0;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          case (q_data_i.kind)
            KIND_KEY_CHAR: place_req = 1'b1;
            KIND_KEY_END:  fill_idx_d = 5'd0;
            KIND_MSG_CHAR: begin
              if (!pend_valid_q) begin
                pend_d       = q_data_i.letter;
                pend_valid_d = 1'b1;
              end else if (q_data_i.letter == pend_q) begin
                pair_a_d = pend_q;
                pair_b_d = FillerLetter;
              end else begin
                pair_a_d     = pend_q;
                pair_b_d     = q_data_i.letter;
                pend_d       = 5'd0;
                pend_valid_d = 1'b0;
              end
            end
            KIND_MSG_END: begin
              if (pend_valid_q) begin
                pair_a_d     = pend_q;
                pair_b_d     = FillerLetter;
                pend_d       = 5'd0;
                pend_valid_d = 1'b0;
              end
            end
            default: place_req = 1'b0;
          endcase
        end
      end
      ST_FILL: begin
        place_req    = 1'b1;
        place_letter = fill_idx_q;
        fill_idx_d   = fill_idx_q + 5'd1;
      end
      ST_POS:  pos_re = 1'b1;
      ST_SQ:   sq_re = 1'b1;
      ST_OUT:  out_load = slot_free;
      default: place_req = 1'b0;
    endcase
  end

  assign letter_free = (place_letter < 5'(AlphabetSize)) ? !used_q[place_letter] : 1'b0;
  assign place_ok    = place_req && letter_free && (place_letter != cfg_i.drop)
                       && (fill_q < 5'(SquareCells));

  always_comb begin
    used_d = used_q;
    fill_d = fill_q;
    if (place_ok) begin
      used_d[place_letter] = 1'b1;
      fill_d               = fill_q + 5'd1;
    end
  end

  // letters not in the square sit at cell 0
  assign found_a = (pair_a_q < 5'(AlphabetSize)) ? used_q[pair_a_q] : 1'b0;
  assign found_b = (pair_b_q < 5'(AlphabetSize)) ? used_q[pair_b_q] : 1'b0;
  assign pa      = found_a ? pos_rd_a : 5'd0;
  assign pb      = found_b ? pos_rd_b : 5'd0;
  assign ra      = pos_row(pa);
  assign ca      = pos_col(pa);
  assign rb      = pos_row(pb);
  assign cb      = pos_col(pb);

  always_comb begin
    if (ra == rb) begin
      qa = cell_at(ra, step_wrap(ca));
      qb = cell_at(rb, step_wrap(cb));
    end else if (ca == cb) begin
      qa = cell_at(step_wrap(ra), ca);
      qb = cell_at(step_wrap(rb), cb);
    end else begin
      qa = cell_at(ra, cb);
      qb = cell_at(rb, ca);
    end
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_first_d  = out_first_q;
    out_second_d = out_second_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_first_d  = AsciiUpperA[6:0] + {2'b00, sq_rd_a};
      out_second_d = AsciiUpperA[6:0] + {2'b00, sq_rd_b};
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cipher_first  = out_first_q;
  assign out_o.cipher_second = out_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      fill_q       <= '0;
      fill_idx_q   <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      fill_q       <= fill_d;
      fill_idx_q   <= fill_idx_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_a_q     <= pair_a_d;
    pair_b_q     <= pair_b_d;
    out_first_q  <= out_first_d;
    out_second_q <= out_second_d;
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 5'(SquareCells))
    else $error("fill count beyond square");

  a_used_matches_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_q) == int'(fill_q))
    else $error("placed letters and fill count disagree");

  a_sq_after_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQ |-> $past(state_q) == ST_POS)
    else $error("square read without position lookup");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside output step");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_IDLE)
    else $error("queue popped while busy");
`endif

endmodule

// ===== src/playfair_digraph_encryptor_core.sv =====
// Channel  Dir  Payload                       Handshake
// in_i     in   kind[1:0], char_code[7:0]      valid/ready
// out_o    out  cipher_first, cipher_second    valid/ready, registered
// apb      in   merge_keep @0x0, merge_drop @0x4  psel/penable/pwrite, pready tied high
//
// Front takes one transaction per cycle while the op queue has room.
// Back: key letters are placed as popped; end of key runs a fill over all 26 letters;
// digraphs step through pick, position RAM read, square RAM read, output load.
// Reset clears control state; key square contents stay undefined, no clearing pass.
// A full output register holds the back at its output step; a full queue drops in ready.
module playfair_digraph_encryptor_core import pfe_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pfe_in_if.sink              in_i,
  pfe_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [4:0] keep_q, drop_q;
  cfg_t       cfg;
  reg_e       reg_sel;
  logic       cfg_we;

  logic push, full, pop, empty;
  op_t  push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepReset;
      drop_q <= DropReset;
    end else if (cfg_we) begin
      case (reg_sel)
        REG_MERGE_KEEP: keep_q <= pwdata[4:0];
        REG_MERGE_DROP: drop_q <= pwdata[4:0];
        default:        keep_q <= keep_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MERGE_KEEP: prdata = {{(ApbDataW-5){1'b0}}, keep_q};
      REG_MERGE_DROP: prdata = {{(ApbDataW-5){1'b0}}, drop_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg.keep = keep_q;
  assign cfg.drop = drop_q;

  pfe_front u_front (
    .in_i         (in_i),
    .cfg_i        (cfg),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  pfe_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  pfe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_empty_i (empty),
    .q_data_i  (pop_data),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule
